[sv/sorted_unique_set_assert.svh]
// assertion helpers shared by the sorted set block
`ifndef SORTED_UNIQUE_SET_ASSERT_SVH
`define SORTED_UNIQUE_SET_ASSERT_SVH

// checked on every clock edge outside reset
`define SUS_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked on every clock edge, reset included
`define SUS_ASSERT_ANY(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

[sv/sus_pkg.sv]
package sus_pkg;

   localparam int unsigned CAPACITY_DEF = 5;
   localparam int unsigned VALUE_W      = 32;
   localparam int unsigned STATUS_W     = 2;
   localparam int unsigned COUNT_W      = 3;
   localparam int unsigned RSP_TDATA_W  = 8;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_DUP   = 2'd2,
      ST_EMPTY = 2'd3
   } status_type;

   typedef enum logic {
      REQ_INSERT = 1'b0,
      REQ_DELETE = 1'b1
   } req_kind_type;

   // read address source, relative to the walk index or to the fill count
   typedef enum logic [2:0] {
      SEL_IDX   = 3'd0,
      SEL_NEXT  = 3'd1,
      SEL_NEXT2 = 3'd2,
      SEL_PREV  = 3'd3,
      SEL_TOP   = 3'd4
   } addr_sel_type;

   // write address and data source
   typedef enum logic [1:0] {
      WSEL_PLACE = 2'd0,   // new value at idx
      WSEL_UP    = 2'd1,   // read data at idx + 1
      WSEL_DOWN  = 2'd2    // read data at idx
   } wr_sel_type;

   typedef enum logic [2:0] {
      IDX_HOLD  = 3'd0,
      IDX_CLEAR = 3'd1,
      IDX_INC   = 3'd2,
      IDX_DEC   = 3'd3,
      IDX_TOP   = 3'd4
   } idx_op_type;

   typedef struct packed {
      logic         load;
      logic         rd_en;
      addr_sel_type rd_sel;
      idx_op_type   idx_op;
      logic         pos_load;
      logic         wr_en;
      wr_sel_type   wr_sel;
      logic         count_inc;
      logic         count_dec;
      logic         status_we;
      status_type   status;
      logic         rsp_load;
   } sus_cmd_type;

   typedef struct packed {
      req_kind_type kind;
      logic         eq;        // read data equals request value
      logic         gt;        // read data above request value, signed
      logic         last;      // idx + 1 == count
      logic         last2;     // idx + 2 == count
      logic         at_pos;    // idx == insert position
      logic         at_end;    // idx == count
      logic         full;
      logic         empty;
      logic         rsp_busy;  // output register holds an untaken result
   } sus_sts_type;

endpackage

[sv/sus_ram.sv]
module sus_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 8,
   parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/sus_dpath.sv]
`include "sorted_unique_set_assert.svh"

module sus_dpath import sus_pkg::*; #(
   parameter int unsigned CAPACITY = CAPACITY_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_kind,
   input  logic [VALUE_W-1:0]     req_value,
   input  sus_cmd_type            cmd,
   output sus_sts_type            sts,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata
);

   localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int unsigned CW = $clog2(CAPACITY + 1);

   logic [VALUE_W-1:0] value_ff;
   req_kind_type       kind_ff;
   logic [CW-1:0]      idx_ff, idx_in;
   logic [CW-1:0]      pos_ff;
   logic [CW-1:0]      count_ff, count_in;
   status_type         status_ff;
   logic               rsp_valid_ff;
   status_type         rsp_status_ff;
   logic [COUNT_W-1:0] rsp_count_ff;

   logic [CW:0]               idx_wide, count_wide, rd_idx, wr_idx;
   logic [VALUE_W-1:0]        rd_data, wr_data;
   logic [CW+COUNT_W-1:0]     count_ext;

   assign idx_wide   = {1'b0, idx_ff};
   assign count_wide = {1'b0, count_ff};

   always_comb begin
      unique case (cmd.rd_sel)
         SEL_IDX:   rd_idx = idx_wide;
         SEL_NEXT:  rd_idx = idx_wide + (CW+1)'(1);
         SEL_NEXT2: rd_idx = idx_wide + (CW+1)'(2);
         SEL_PREV:  rd_idx = idx_wide - (CW+1)'(1);
         SEL_TOP:   rd_idx = count_wide - (CW+1)'(1);
         default:   rd_idx = idx_wide;
      endcase
   end

   always_comb begin
      unique case (cmd.wr_sel)
         WSEL_UP: begin
            wr_idx  = idx_wide + (CW+1)'(1);
            wr_data = rd_data;
         end
         WSEL_DOWN: begin
            wr_idx  = idx_wide;
            wr_data = rd_data;
         end
         default: begin
            wr_idx  = idx_wide;
            wr_data = value_ff;
         end
      endcase
   end

   sus_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (CAPACITY),
      .AW    (AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (cmd.wr_en),
      .wr_addr (wr_idx[AW-1:0]),
      .wr_data (wr_data),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_idx[AW-1:0]),
      .rd_data (rd_data)
   );

   always_comb begin
      case (cmd.idx_op)
         IDX_CLEAR: idx_in = '0;
         IDX_INC:   idx_in = idx_ff + CW'(1);
         IDX_DEC:   idx_in = idx_ff - CW'(1);
         IDX_TOP:   idx_in = count_ff - CW'(1);
         default:   idx_in = idx_ff;
      endcase
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.count_inc) begin
         count_in = count_ff + CW'(1);
      end else if (cmd.count_dec) begin
         count_in = count_ff - CW'(1);
      end
   end

   assign count_ext = {{COUNT_W{1'b0}}, count_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         count_ff <= count_in;
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         value_ff <= req_value;
         kind_ff  <= req_kind_type'(req_kind);
      end
      if (cmd.pos_load) begin
         pos_ff <= idx_ff;
      end
      if (cmd.status_we) begin
         status_ff <= cmd.status;
      end
      if (cmd.rsp_load) begin
         rsp_status_ff <= status_ff;
         rsp_count_ff  <= count_ext[COUNT_W-1:0];
      end
   end

   assign sts.kind     = kind_ff;
   assign sts.eq       = (rd_data == value_ff);
   assign sts.gt       = ($signed(rd_data) > $signed(value_ff));
   assign sts.last     = ((idx_wide + (CW+1)'(1)) == count_wide);
   assign sts.last2    = ((idx_wide + (CW+1)'(2)) == count_wide);
   assign sts.at_pos   = (idx_ff == pos_ff);
   assign sts.at_end   = (idx_ff == count_ff);
   assign sts.full     = (count_ff == CW'(CAPACITY));
   assign sts.empty    = (count_ff == '0);
   assign sts.rsp_busy = rsp_valid_ff && !rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W-COUNT_W-STATUS_W){1'b0}}, rsp_count_ff, rsp_status_ff};

   `SUS_ASSERT(a_count_range, count_ff <= CW'(CAPACITY), "fill count above capacity")
   `SUS_ASSERT(a_wr_bound, cmd.wr_en |-> wr_idx <= count_wide, "write beyond top of set")
   `SUS_ASSERT(a_rsp_free, cmd.rsp_load |-> !rsp_valid_ff || rsp_tready, "result overwritten")
   `SUS_ASSERT_ANY(a_reset_clear, reset |=> !rsp_valid_ff && count_ff == '0, "reset not clean")

endmodule

[sv/sus_ctrl.sv]
module sus_ctrl import sus_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  sus_sts_type sts,
   output sus_cmd_type cmd
);

   typedef enum logic [6:0] {
      S_IDLE     = 7'b0000001,
      S_CHECK    = 7'b0000010,
      S_SCAN     = 7'b0000100,
      S_SHIFT_UP = 7'b0001000,
      S_PLACE    = 7'b0010000,
      S_SHIFT_DN = 7'b0100000,
      S_DONE     = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in      = state_ff;
      req_tready    = 1'b0;
      cmd.load      = 1'b0;
      cmd.rd_en     = 1'b0;
      cmd.rd_sel    = SEL_IDX;
      cmd.idx_op    = IDX_HOLD;
      cmd.pos_load  = 1'b0;
      cmd.wr_en     = 1'b0;
      cmd.wr_sel    = WSEL_PLACE;
      cmd.count_inc = 1'b0;
      cmd.count_dec = 1'b0;
      cmd.status_we = 1'b0;
      cmd.status    = ST_OK;
      cmd.rsp_load  = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load   = 1'b1;
               cmd.idx_op = IDX_CLEAR;
               state_in   = S_CHECK;
            end
         end
         S_CHECK: begin
            if (sts.kind == REQ_INSERT) begin
               if (sts.full) begin
                  cmd.status_we = 1'b1;
                  cmd.status    = ST_FULL;
                  state_in      = S_DONE;
               end else if (sts.at_end) begin
                  state_in = S_PLACE;
               end else begin
                  cmd.rd_en = 1'b1;
                  state_in  = S_SCAN;
               end
            end else begin
               if (sts.empty) begin
                  cmd.status_we = 1'b1;
                  cmd.status    = ST_EMPTY;
                  state_in      = S_DONE;
               end else begin
                  cmd.rd_en = 1'b1;
                  state_in  = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            if (sts.kind == REQ_INSERT) begin
               if (sts.eq) begin
                  cmd.status_we = 1'b1;
                  cmd.status    = ST_DUP;
                  state_in      = S_DONE;
               end else if (sts.gt) begin
                  cmd.pos_load = 1'b1;
                  cmd.rd_en    = 1'b1;
                  cmd.rd_sel   = SEL_TOP;
                  cmd.idx_op   = IDX_TOP;
                  state_in     = S_SHIFT_UP;
               end else if (sts.last) begin
                  cmd.idx_op = IDX_INC;
                  state_in   = S_PLACE;
               end else begin
                  cmd.rd_en  = 1'b1;
                  cmd.rd_sel = SEL_NEXT;
                  cmd.idx_op = IDX_INC;
               end
            end else begin
               if (sts.eq) begin
                  if (sts.last) begin
                     cmd.count_dec = 1'b1;
                     cmd.status_we = 1'b1;
                     cmd.status    = ST_OK;
                     state_in      = S_DONE;
                  end else begin
                     cmd.rd_en  = 1'b1;
                     cmd.rd_sel = SEL_NEXT;
                     state_in   = S_SHIFT_DN;
                  end
               end else if (sts.gt || sts.last) begin
                  cmd.status_we = 1'b1;
                  cmd.status    = ST_OK;
                  state_in      = S_DONE;
               end else begin
                  cmd.rd_en  = 1'b1;
                  cmd.rd_sel = SEL_NEXT;
                  cmd.idx_op = IDX_INC;
               end
            end
         end
         S_SHIFT_UP: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = WSEL_UP;
            if (sts.at_pos) begin
               state_in = S_PLACE;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = SEL_PREV;
               cmd.idx_op = IDX_DEC;
            end
         end
         S_PLACE: begin
            cmd.wr_en     = 1'b1;
            cmd.wr_sel    = WSEL_PLACE;
            cmd.count_inc = 1'b1;
            cmd.status_we = 1'b1;
            cmd.status    = ST_OK;
            state_in      = S_DONE;
         end
         S_SHIFT_DN: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = WSEL_DOWN;
            if (sts.last2) begin
               cmd.count_dec = 1'b1;
               cmd.status_we = 1'b1;
               cmd.status    = ST_OK;
               state_in      = S_DONE;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = SEL_NEXT2;
               cmd.idx_op = IDX_INC;
            end
         end
         S_DONE: begin
            if (!sts.rsp_busy) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[sv/sorted_unique_set.sv]
// Ordered set of up to CAPACITY distinct signed 32-bit values held in ascending order in a
// small single-port-write RAM. A request transfer on req_ carries an insert or a delete; each
// request gives exactly one result transfer on rsp_ with a status (ok, full, duplicate, empty)
// and the count held afterwards (low 3 bits). A full set refuses an insert before the duplicate
// check; an empty set refuses a delete; deleting an absent value reports ok and changes nothing.
// One request is worked at a time: a controller walks the RAM one entry per cycle, first
// scanning up from slot 0 for the match or insert position, then moving the larger entries
// one slot up (insert) or down (delete), one read and one write per cycle. An insert ends
// with a write that places the new value. The result sits in an output register, so the
// next request is taken while it waits.
// Reset empties the set at once; no clearing pass is needed.
module sorted_unique_set import sus_pkg::*; #(
   parameter int unsigned CAPACITY = CAPACITY_DEF   // 2 .. 64
) (
   input  logic                   clock,
   input  logic                   reset,
   // request channel
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [VALUE_W-1:0]     req_tdata,   // [31:0] value, signed
   input  logic [0:0]             req_tuser,   // [0] req_type: 0 insert, 1 delete
   // result channel
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata    // [1:0] status, [4:2] count, [7:5] zero
);

   // command and status between sequencer and datapath
   sus_cmd_type cmd;
   sus_sts_type sts;

   // sequencer: decides refusals, scan, shift and placement steps
   sus_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // datapath: entry RAM, walk index, insert position, fill count, result register
   sus_dpath #(
      .CAPACITY (CAPACITY)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_kind   (req_tuser[0]),
      .req_value  (req_tdata),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

[verif/tb_sorted_unique_set.sv]
module tb_sorted_unique_set;
   import sus_pkg::*;

   // one expected result: status and low count bits
   typedef struct {
      status_type              status;
      logic [COUNT_W-1:0]      count;
   } set_result_type;

   localparam int unsigned DRAIN_CYCLES = 2 * CAPACITY_DEF + 6;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [VALUE_W-1:0]     req_tdata = '0;   // [31:0] value, signed
   logic [0:0]             req_tuser = '0;   // [0] req_type: 0 insert, 1 delete
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;        // [1:0] status, [4:2] count, [7:5] zero

   // predictor state: the held values in ascending signed order
   logic signed [VALUE_W-1:0] held_values[$];
   // results predicted but not yet seen on the rsp_ side
   set_result_type              pending_results[$];
   int unsigned                 error_count = 0;
   // while set, neither side inserts idle cycles
   bit                          steady = 1'b0;

   sorted_unique_set u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #2 clock = ~clock;

   // receiver back-pressure: tready drops with a chance of about 14 in a hundred, never while steady
   always @(posedge clock) begin
      rsp_tready <= steady || ($urandom_range(99) >= 14);
   end

   task automatic report_error(string msg);
      error_count++;
      $display("error at %0t: %s", $realtime, msg);
   endtask

   // apply one request to the predicted set and queue the result it gives
   function automatic void apply_request(req_kind_type kind, logic signed [VALUE_W-1:0] v);
      status_type     st;
      int             hit = -1;
      int             pos = 0;
      set_result_type res;
      st = ST_OK;
      foreach (held_values[i])
         if (held_values[i] == v) hit = i;
      if (kind == REQ_INSERT) begin
         // full set wins over duplicate
         if (held_values.size() >= CAPACITY_DEF) begin
            st = ST_FULL;
         end else if (hit >= 0) begin
            st = ST_DUP;
         end else begin
            while (pos < held_values.size() && held_values[pos] < v) pos++;
            held_values.insert(pos, v);
         end
      end else begin
         // absent value on delete is still ok
         if (held_values.size() == 0) begin
            st = ST_EMPTY;
         end else if (hit >= 0) begin
            held_values.delete(hit);
         end
      end
      res.status = st;
      res.count  = COUNT_W'(held_values.size());
      pending_results.push_back(res);
   endfunction

   // drive one request and hold it until the block takes the transfer
   task automatic send_request(req_kind_type kind, logic [VALUE_W-1:0] v);
      if (!steady) begin
         while ($urandom_range(99) < 14) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= v;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      apply_request(kind, v);
   endtask

   // sender holds off until every predicted result has come back
   task automatic wait_for_drain();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // compare one result transfer with the oldest prediction
   task automatic check_result(logic [RSP_TDATA_W-1:0] data);
      set_result_type want;
      if (pending_results.size() == 0) begin
         report_error($sformatf("result with nothing pending, tdata %h", data));
      end else begin
         want = pending_results.pop_front();
         if (data[1:0] !== want.status)
            report_error($sformatf("status %0d, predicted %s", data[1:0], want.status.name()));
         if (data[4:2] !== want.count)
            report_error($sformatf("count %0d, predicted %0d", data[4:2], want.count));
         if (data[7:5] !== 3'b000)
            report_error($sformatf("padding bits %b not zero", data[7:5]));
      end
   endtask

   // every result transfer goes through the checker
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) check_result(rsp_tdata);
   end

   // value source: mostly small numbers so duplicates and hits on delete are common,
   // some corner values, and full-range words so every bit toggles
   function automatic logic [VALUE_W-1:0] pick_value();
      logic [VALUE_W-1:0] corner[8];
      corner = '{32'h8000_0000, 32'h8000_0001, 32'hFFFF_FFFE, 32'hFFFF_FFFF,
                 32'h0000_0000, 32'h0000_0001, 32'h7FFF_FFFE, 32'h7FFF_FFFF};
      case ($urandom_range(9))
         0, 1, 2: return $urandom;
         3:       return corner[$urandom_range(7)];
         default: return VALUE_W'($urandom_range(12)) - VALUE_W'(6);
      endcase
   endfunction

   // walk the corner cases in a fixed order
   task automatic test_directed_cases();
      send_request(REQ_DELETE, 32'd0);           // delete on an empty set
      send_request(REQ_INSERT, 32'd0);
      send_request(REQ_INSERT, 32'h7FFF_FFFF);   // largest value goes last
      send_request(REQ_INSERT, 32'h8000_0000);   // smallest value goes first
      send_request(REQ_INSERT, 32'hFFFF_FFFF);
      send_request(REQ_INSERT, 32'd1);           // set now full
      send_request(REQ_INSERT, 32'd123);         // refused, full
      send_request(REQ_INSERT, 32'd0);           // full checked before duplicate
      send_request(REQ_DELETE, 32'd42);          // absent value, nothing changes
      send_request(REQ_DELETE, 32'h7FFF_FFFF);   // top entry
      send_request(REQ_DELETE, 32'h8000_0000);   // bottom entry, all move down
      send_request(REQ_DELETE, 32'd0);           // middle entry
      send_request(REQ_INSERT, 32'hFFFF_FFFF);   // duplicate
      send_request(REQ_INSERT, 32'd1);           // duplicate
      send_request(REQ_DELETE, 32'hFFFF_FFFF);
      send_request(REQ_DELETE, 32'd1);           // back to empty
      send_request(REQ_DELETE, 32'd1);           // empty again
      // inserts below the top entry force a shift on every insert after the first
      send_request(REQ_INSERT, 32'd30);
      send_request(REQ_INSERT, 32'd20);
      send_request(REQ_INSERT, 32'd10);
      send_request(REQ_INSERT, 32'd25);
      send_request(REQ_DELETE, 32'd20);
      send_request(REQ_DELETE, 32'd10);
      send_request(REQ_DELETE, 32'd30);
      send_request(REQ_DELETE, 32'd25);
   endtask

   // random mix with idling on both sides; phases lean toward inserts or deletes
   // so the set keeps swinging between full and empty
   task automatic test_random_mix(int unsigned n_items);
      req_kind_type       kind;
      logic [VALUE_W-1:0] v;
      bit                 grow;
      for (int unsigned i = 0; i < n_items; i++) begin
         grow = ((i / 40) % 2) == 0;
         if (grow) kind = ($urandom_range(99) < 75) ? REQ_INSERT : REQ_DELETE;
         else      kind = ($urandom_range(99) < 75) ? REQ_DELETE : REQ_INSERT;
         if (kind == REQ_DELETE && held_values.size() != 0 && $urandom_range(99) < 60)
            v = held_values[$urandom_range(held_values.size() - 1)];
         else
            v = pick_value();
         send_request(kind, v);
         // now and then let the block run completely dry
         if (i % 150 == 149) wait_for_drain();
      end
   endtask

   // back-to-back transfers with no idling on either side
   task automatic test_steady_stream(int unsigned n_items);
      req_kind_type       kind;
      logic [VALUE_W-1:0] v;
      steady = 1'b1;
      for (int unsigned i = 0; i < n_items; i++) begin
         kind = $urandom_range(1) ? REQ_DELETE : REQ_INSERT;
         if (kind == REQ_DELETE && held_values.size() != 0 && $urandom_range(1))
            v = held_values[$urandom_range(held_values.size() - 1)];
         else
            v = pick_value();
         send_request(kind, v);
      end
      steady = 1'b0;
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_cases();
      wait_for_drain();
      test_random_mix(1125);
      wait_for_drain();
      test_steady_stream(400);
      wait_for_drain();
      // let any stray result show up
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_results.size() != 0)
         report_error($sformatf("%0d results never arrived", pending_results.size()));
      if (error_count == 0) begin
         $display("sorted_unique_set: match");
      end else begin
         $display("sorted_unique_set: mismatch");
      end
      $finish;
   end

   // hang guard, far beyond the slowest correct run
   initial begin
      #2000000;
      $display("sorted_unique_set: mismatch");
      $finish;
   end

endmodule
